@@ sv/mred_pkg.sv @@
package mred_pkg;

    localparam int unsigned MAX_STATUS_LEN = 256;
    localparam int unsigned LEN_W          = $clog2(MAX_STATUS_LEN + 1);
    localparam int unsigned LEFT_W         = 4;

    localparam logic [7:0] ESC_PORT    = 8'h91;
    localparam logic [7:0] ESC_STATUS  = 8'h80;
    localparam logic [7:0] LIT_PORT    = 8'hB1;
    localparam logic [7:0] SEL_SEC     = 8'h33;
    localparam logic [7:0] SEL_PRI     = 8'h31;
    localparam logic [7:0] PORT_RX     = 8'h30;
    localparam logic [7:0] PORT_ECHO   = 8'h31;
    localparam logic [7:0] PORT_SEC    = 8'h32;
    localparam logic [7:0] MSG_END     = 8'h00;

    typedef enum logic [1:0] {
        KIND_PRIMARY   = 2'd0,
        KIND_SECONDARY = 2'd1,
        KIND_STATUS    = 2'd2,
        KIND_UNKNOWN   = 2'd3
    } kind_t;

    typedef struct packed {
        logic              p80;
        logic              p91;
        logic              sec;
        logic              echo;
        logic [LEFT_W-1:0] bytes_left;
        logic              zt;
        logic [LEN_W-1:0]  msg_len;
    } state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic       first;
        logic       last;
        logic       echo;
        logic       disc;
    } result_t;

    // status codes that are swallowed without a result
    function automatic logic is_ignored(input logic [7:0] b);
        logic r;
        unique case (b)
            8'h06, 8'h09, 8'h10, 8'h33, 8'h34, 8'h51, 8'h56,
            8'h59, 8'h5A, 8'h65, 8'h69, 8'h80, 8'hFE: r = 1'b1;
            default:                                  r = 1'b0;
        endcase
        return r;
    endfunction

    // codes that open a zero-terminated message
    function automatic logic is_variable(input logic [7:0] b);
        logic r;
        unique case (b)
            8'h20, 8'h21, 8'h22, 8'h26, 8'h27, 8'h28,
            8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E: r = 1'b1;
            default:                          r = 1'b0;
        endcase
        return r;
    endfunction

    // link disconnect codes, one trailing byte
    function automatic logic is_disconnect(input logic [7:0] b);
        return (b == 8'h23) || (b == 8'h24);
    endfunction

    // trailing byte count of fixed messages, zero if not one
    function automatic logic [LEFT_W-1:0] fixed_len(input logic [7:0] b);
        logic [LEFT_W-1:0] r;
        unique case (b)
            8'h70:   r = LEFT_W'(8);
            8'h71:   r = LEFT_W'(1);
            8'h72:   r = LEFT_W'(7 * 2);
            8'h73:   r = LEFT_W'(1);
            8'h75:   r = LEFT_W'(4);
            8'h7F:   r = LEFT_W'(2);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ sv/mred_decode.sv @@
module mred_decode
    import mred_pkg::*;
(
    input  state_t     st,
    input  logic [7:0] rx,
    output state_t     st_next,
    output logic       has_result,
    output result_t    res
);

    logic [LEN_W-1:0]  len_inc;
    logic [LEFT_W-1:0] flen;
    logic              msg_done;

    assign len_inc  = (st.msg_len < LEN_W'(MAX_STATUS_LEN)) ? st.msg_len + LEN_W'(1)
                                                             : st.msg_len;
    assign flen     = fixed_len(rx);
    assign msg_done = (rx == MSG_END) || (len_inc >= LEN_W'(MAX_STATUS_LEN));

    always_comb
    begin
        st_next    = st;
        has_result = 1'b0;
        res.kind   = st.sec ? KIND_SECONDARY : KIND_PRIMARY;
        res.value  = rx;
        res.first  = 1'b0;
        res.last   = 1'b0;
        res.echo   = st.sec ? 1'b0 : st.echo;
        res.disc   = 1'b0;

        priority if (!st.p91 && rx == ESC_PORT)
        begin
            st_next.p91 = 1'b1;
        end
        else if (st.p91)
        begin
            st_next.p91 = 1'b0;
            priority if (rx == SEL_SEC)
            begin
                st_next.sec = 1'b1;
            end
            else if (rx == SEL_PRI)
            begin
                st_next.sec = 1'b0;
            end
            else if (rx == LIT_PORT)
            begin
                has_result = 1'b1;
                res.value  = ESC_PORT;
            end
            else
            begin
                has_result = 1'b0;
            end
        end
        else if (!st.p80)
        begin
            if (rx == ESC_STATUS)
            begin
                st_next.p80 = 1'b1;
            end
            else
            begin
                has_result = 1'b1;
            end
        end
        else
        begin
            st_next.p80 = 1'b0;
            res.echo    = 1'b0;
            res.kind    = KIND_STATUS;
            priority if (st.zt)
            begin
                st_next.msg_len = len_inc;
                st_next.zt      = !msg_done;
                has_result      = 1'b1;
                res.last        = msg_done;
            end
            else if (st.bytes_left != '0)
            begin
                st_next.bytes_left = st.bytes_left - LEFT_W'(1);
                has_result         = 1'b1;
                res.last           = (st.bytes_left == LEFT_W'(1));
            end
            else if (is_ignored(rx))
            begin
                has_result = 1'b0;
            end
            else if (is_variable(rx))
            begin
                st_next.zt      = 1'b1;
                st_next.msg_len = LEN_W'(1);
                has_result      = 1'b1;
                res.first       = 1'b1;
            end
            else if (is_disconnect(rx))
            begin
                st_next.bytes_left = LEFT_W'(1);
                st_next.msg_len    = LEN_W'(1);
                has_result         = 1'b1;
                res.first          = 1'b1;
                res.disc           = 1'b1;
            end
            else if (rx == PORT_RX)
            begin
                st_next.sec  = 1'b0;
                st_next.echo = 1'b0;
            end
            else if (rx == PORT_ECHO)
            begin
                st_next.sec  = 1'b0;
                st_next.echo = 1'b1;
            end
            else if (rx == PORT_SEC)
            begin
                st_next.sec = 1'b1;
            end
            else if (flen != '0)
            begin
                st_next.bytes_left = flen;
                st_next.msg_len    = LEN_W'(1);
                has_result         = 1'b1;
                res.first          = 1'b1;
            end
            else
            begin
                has_result = 1'b1;
                res.kind   = KIND_UNKNOWN;
            end
        end
    end

endmodule

@@ sv/modem_rx_escape_demux.sv @@
// channel | handshake            | payload
// in      | in_valid / in_ready  | rx_byte, burst_end
// out     | out_valid / out_ready| kind, value, msg_first, msg_last, echo_flag, disconnect
//
// one byte per cycle sustained while the result is not stalled; a byte is held in the input register,
// is decoded against the escape state and lands in the result register
// reset clears the valid flags of both registers and the escape state, secondary port selected
// a stalled result holds the input register; bytes that give no result still
// pass through the decode and update the state
module modem_rx_escape_demux
    import mred_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       burst_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] value,
    output logic       msg_first,
    output logic       msg_last,
    output logic       echo_flag,
    output logic       disconnect
);

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    state_t     state_reg;
    state_t     state_next;
    logic       out_valid_reg;
    result_t    res_reg;
    result_t    res_next;
    logic       has_result;
    logic       advance;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || !out_valid_reg || out_ready;

    mred_decode u_decode (
        .st         (state_reg),
        .rx         (s1_byte_reg),
        .st_next    (state_next),
        .has_result (has_result),
        .res        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg <= '{p80: 1'b0, p91: 1'b0, sec: 1'b1, echo: 1'b0,
                           bytes_left: '0, zt: 1'b0, msg_len: '0};
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                state_reg <= state_next;
                out_valid_reg <= has_result;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= rx_byte;
        end
        if (advance && has_result)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = res_reg.kind;
    assign value      = res_reg.value;
    assign msg_first  = res_reg.first;
    assign msg_last   = res_reg.last;
    assign echo_flag  = res_reg.echo;
    assign disconnect = res_reg.disc;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.msg_len <= LEN_W'(MAX_STATUS_LEN))
        else $error("message length beyond limit");

    a_one_msg_mode: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg.zt && state_reg.bytes_left != '0))
        else $error("fixed and variable message both open");

    a_echo_primary: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && res_reg.kind != KIND_PRIMARY |-> !echo_flag)
        else $error("echo flag on non-primary result");

    a_disc_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && disconnect |-> msg_first && res_reg.kind == KIND_STATUS)
        else $error("disconnect without message start");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !out_ready |=> s1_valid_reg && $stable(state_reg))
        else $error("decode advanced into a stalled result");

endmodule
